@@ sv/ams_pkg.sv @@
// ----------------------------------------------------------------------------
// ams_pkg
// Shared types and constants for the adjacency matrix store unit.
// ----------------------------------------------------------------------------
package ams_pkg;

    localparam int          NODE_CAP         = 16;
    localparam logic [4:0]  NODE_COUNT_RESET = 5'd16;
    localparam logic [6:0]  EDGE_COUNT_MAX   = 7'd127;

    typedef enum logic [1:0] {
        OP_ADD_EDGE  = 2'd0,
        OP_READ      = 2'd1,
        OP_NEIGHBORS = 2'd2,
        OP_DEGREE    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_WRITE_REV,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic latch;
        logic clr;
        logic wr_fwd;
        logic wr_rev;
        logic cnt_inc;
        logic scan_run;
        logic emit_add;
        logic add_acc;
        logic emit_read;
        logic emit_final;
    } t_cmd;

    typedef struct packed {
        t_opcode op;
        t_opcode req_op;
        logic    clr_done;
        logic    add_ok;
        logic    scan_done;
    } t_sts;

endpackage

@@ sv/ams_ctrl.sv @@
// ----------------------------------------------------------------------------
// ams_ctrl
// Sequencer for the adjacency matrix store: clearing pass, request dispatch,
// edge insertion and row scans.
// ----------------------------------------------------------------------------
module ams_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output ams_pkg::t_cmd o_cmd,
    input  ams_pkg::t_sts i_sts
);
    import ams_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    if (i_sts.req_op == OP_ADD_EDGE || i_sts.req_op == OP_READ) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_sts.op == OP_ADD_EDGE && i_sts.add_ok) begin
                    n_state = ST_WRITE_REV;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_WRITE_REV: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != ST_IDLE);
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
            end
            ST_IDLE: begin
                o_cmd.latch = i_start;
            end
            ST_READ: begin
            end
            ST_CHECK: begin
                if (i_sts.op == OP_ADD_EDGE) begin
                    if (i_sts.add_ok) begin
                        o_cmd.wr_fwd  = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end else begin
                        o_cmd.emit_add = 1'b1;
                    end
                end else begin
                    o_cmd.emit_read = 1'b1;
                end
            end
            ST_WRITE_REV: begin
                o_cmd.wr_rev   = 1'b1;
                o_cmd.emit_add = 1'b1;
                o_cmd.add_acc  = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_run   = 1'b1;
                o_cmd.emit_final = i_sts.scan_done;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ sv/ams_dpath.sv @@
// ----------------------------------------------------------------------------
// ams_dpath
// Datapath of the adjacency matrix store: weight memory, node count register,
// edge counter, row scan pipeline and result registers.
// ----------------------------------------------------------------------------
module ams_dpath #(
    parameter int MAX_NODES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ams_pkg::t_cmd i_cmd,
    output ams_pkg::t_sts o_sts,
    input  logic          i_cfg_we,
    input  logic [4:0]    i_cfg_wdata,
    input  logic [1:0]    i_opcode,
    input  logic [3:0]    i_node_u,
    input  logic [3:0]    i_node_v,
    input  logic [15:0]   i_edge_weight,
    output logic          o_valid,
    output logic [3:0]    o_neighbor_node,
    output logic [15:0]   o_weight_out,
    output logic [4:0]    o_degree_out,
    output logic [6:0]    o_edge_total,
    output logic          o_accepted,
    output logic          o_empty_list,
    output logic          o_last
);
    import ams_pkg::*;

    localparam int         NODES   = (MAX_NODES < NODE_CAP) ? MAX_NODES : NODE_CAP;
    localparam int         IW      = $clog2(NODES);
    localparam int         AW      = 2 * IW;
    localparam int         DEPTH   = 1 << AW;
    localparam logic [4:0] NODES_W = 5'(NODES);

    logic [15:0]   mem [DEPTH];
    logic [15:0]   r_rdata;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          wr_en;

    logic [AW-1:0] r_clr_addr;
    logic [4:0]    r_node_count;
    logic [4:0]    n_eff;
    logic [6:0]    r_cnt;

    t_opcode       r_op;
    logic [3:0]    r_u;
    logic [3:0]    r_v;
    logic [15:0]   r_w;
    logic          r_u_ok;
    logic          r_v_ok;
    logic [4:0]    r_lim;

    logic [4:0]    r_col;
    logic          r_rd_vld;
    logic [3:0]    r_rd_col;
    logic [4:0]    r_deg;
    logic          r_pend_vld;
    logic [3:0]    r_pend_col;
    logic [15:0]   r_pend_w;
    logic          issue;
    logic          hit;

    logic          r_out_vld;
    logic [3:0]    r_out_nb;
    logic [15:0]   r_out_w;
    logic [4:0]    r_out_deg;
    logic [6:0]    r_out_tot;
    logic          r_out_acc;
    logic          r_out_empty;
    logic          r_out_last;
    logic          n_out_vld;
    logic [3:0]    n_out_nb;
    logic [15:0]   n_out_w;
    logic [4:0]    n_out_deg;
    logic          n_out_acc;
    logic          n_out_empty;
    logic          n_out_last;

    assign n_eff = (r_node_count > NODES_W) ? NODES_W : r_node_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= t_opcode'(i_opcode);
            r_u    <= i_node_u;
            r_v    <= i_node_v;
            r_w    <= i_edge_weight;
            r_u_ok <= ({1'b0, i_node_u} < n_eff);
            r_v_ok <= ({1'b0, i_node_v} < n_eff);
            r_lim  <= ({1'b0, i_node_u} < n_eff) ? n_eff : 5'd0;
        end
    end

    // Memory ports. Only nodes below the active count reach the memory, so
    // the low index bits address it without aliasing.
    always_comb begin
        wr_en   = i_cmd.clr | i_cmd.wr_fwd | i_cmd.wr_rev;
        wr_data = r_w;
        priority if (i_cmd.clr) begin
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (i_cmd.wr_rev) begin
            wr_addr = {r_v[IW-1:0], r_u[IW-1:0]};
        end else begin
            wr_addr = {r_u[IW-1:0], r_v[IW-1:0]};
        end
        if (i_cmd.scan_run) begin
            rd_addr = {r_u[IW-1:0], r_col[IW-1:0]};
        end else begin
            rd_addr = {r_u[IW-1:0], r_v[IW-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc && r_cnt != EDGE_COUNT_MAX) begin
            r_cnt <= r_cnt + 7'd1;
        end
    end

    assign issue = i_cmd.scan_run & (r_col < r_lim);
    assign hit   = r_rd_vld & (r_rdata != 16'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (i_cmd.latch) begin
                r_pend_vld <= 1'b0;
            end else if (hit) begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_col <= r_col[3:0];
        if (i_cmd.latch) begin
            r_col <= '0;
            r_deg <= '0;
        end else begin
            if (issue) begin
                r_col <= r_col + 5'd1;
            end
            if (hit) begin
                r_deg      <= r_deg + 5'd1;
                r_pend_col <= r_rd_col;
                r_pend_w   <= r_rdata;
            end
        end
    end

    always_comb begin
        n_out_vld   = 1'b0;
        n_out_nb    = '0;
        n_out_w     = '0;
        n_out_deg   = '0;
        n_out_acc   = 1'b0;
        n_out_empty = 1'b0;
        n_out_last  = 1'b0;
        priority if (i_cmd.emit_add) begin
            n_out_vld  = 1'b1;
            n_out_acc  = i_cmd.add_acc;
            n_out_last = 1'b1;
        end else if (i_cmd.emit_read) begin
            n_out_vld  = 1'b1;
            n_out_w    = (r_u_ok && r_v_ok) ? r_rdata : 16'd0;
            n_out_last = 1'b1;
        end else if (i_cmd.emit_final) begin
            n_out_vld  = 1'b1;
            n_out_last = 1'b1;
            if (r_op == OP_DEGREE) begin
                n_out_deg = r_deg;
            end else if (r_pend_vld) begin
                n_out_nb = r_pend_col;
                n_out_w  = r_pend_w;
            end else begin
                n_out_empty = 1'b1;
            end
        end else if (i_cmd.scan_run && r_op == OP_NEIGHBORS && hit && r_pend_vld) begin
            n_out_vld = 1'b1;
            n_out_nb  = r_pend_col;
            n_out_w   = r_pend_w;
        end else begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_nb    <= n_out_nb;
        r_out_w     <= n_out_w;
        r_out_deg   <= n_out_deg;
        r_out_tot   <= r_cnt;
        r_out_acc   <= n_out_acc;
        r_out_empty <= n_out_empty;
        r_out_last  <= n_out_last;
    end

    assign o_sts.op        = r_op;
    assign o_sts.req_op    = t_opcode'(i_opcode);
    assign o_sts.clr_done  = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.add_ok    = r_u_ok & r_v_ok & (r_u != r_v) & (r_w != 16'd0)
                             & (r_rdata == 16'd0);
    assign o_sts.scan_done = ~issue & ~r_rd_vld;

    assign o_valid         = r_out_vld;
    assign o_neighbor_node = r_out_nb;
    assign o_weight_out    = r_out_w;
    assign o_degree_out    = r_out_deg;
    assign o_edge_total    = r_out_tot;
    assign o_accepted      = r_out_acc;
    assign o_empty_list    = r_out_empty;
    assign o_last          = r_out_last;

endmodule

@@ sv/adjacency_matrix_store_unit.sv @@
// ----------------------------------------------------------------------------
// adjacency_matrix_store_unit
// Symmetric weighted adjacency matrix for an undirected graph with an edge
// counter, serving add edge, read weight, list neighbors and degree requests.
// ----------------------------------------------------------------------------
// After reset the block sweeps the weight memory to zero, one cell per cycle,
// over all (2**clog2(min(MAX_NODES,16)))**2 cells (256 at the default size),
// with o_busy high. A request is taken when i_start is high and o_busy is
// low. Add edge and read weight go through one memory read, a check, and for
// an accepted edge a second write for the mirrored cell. List neighbors and
// degree scan a valid row of n active nodes through the single read port of
// the weight memory, which fetches one cell of the row per cycle; an invalid
// row is not scanned. Results appear in the cycle after they are produced,
// each for exactly one cycle with o_valid high, and the receiver has no way
// to stall them; the last result of a request shows o_last high, and the
// next request may be taken in that same cycle.
module adjacency_matrix_store_unit #(
    parameter int MAX_NODES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_node_u,
    input  logic [3:0]  i_node_v,
    input  logic [15:0] i_edge_weight,
    output logic        o_valid,
    output logic [3:0]  o_neighbor_node,
    output logic [15:0] o_weight_out,
    output logic [4:0]  o_degree_out,
    output logic [6:0]  o_edge_total,
    output logic        o_accepted,
    output logic        o_empty_list,
    output logic        o_last
);
    import ams_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ams_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    ams_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_opcode        (i_opcode),
        .i_node_u        (i_node_u),
        .i_node_v        (i_node_v),
        .i_edge_weight   (i_edge_weight),
        .o_valid         (o_valid),
        .o_neighbor_node (o_neighbor_node),
        .o_weight_out    (o_weight_out),
        .o_degree_out    (o_degree_out),
        .o_edge_total    (o_edge_total),
        .o_accepted      (o_accepted),
        .o_empty_list    (o_empty_list),
        .o_last          (o_last)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("Request accepted but the block did not go busy.");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr, cmd.wr_fwd, cmd.wr_rev}))
        else $error("More than one memory write source active.");

    a_final_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !o_busy)
        else $error("Final result shown while the block is still busy.");

    a_partial_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_busy)
        else $error("Intermediate neighbor result outside a row scan.");

    a_accepted_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted) |-> (o_edge_total != 7'd0))
        else $error("Accepted edge with a zero edge count.");

endmodule
